FILE: rtl/restricted_circular_deque_macros.svh
// Assertion macros for the restricted circular deque checker.
// Needs nothing else; taken in by `include where assertions are written.
`ifndef RESTRICTED_CIRCULAR_DEQUE_MACROS_SVH
`define RESTRICTED_CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication
`define RCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcd assertion failed");

// next-cycle implication
`define RCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcd assertion failed");

// next-cycle implication, checked during reset as well
`define RCD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rcd assertion failed");

`endif

FILE: rtl/rcd_pkg.sv
// Shared types and codes for the restricted circular deque.
// No dependencies; used by the top level and its checker.
package rcd_pkg;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic {
      SIDE_LEFT  = 1'b0,
      SIDE_RIGHT = 1'b1
   } side_type;

   typedef enum logic {
      MODE_IN_RESTRICTED  = 1'b0,
      MODE_OUT_RESTRICTED = 1'b1
   } mode_type;

   // register indexes on the csr port
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_SIDE = 1'b1;

endpackage

FILE: rtl/restricted_circular_deque.sv
// Restricted double-ended queue over a circular store of DEPTH 32-bit entries.
// One item (push or pop) is taken per cycle while req_stall is low; each gives
// one result, held first in the synchronous store read and pending registers and
// then in the output register. Pointers and the empty flag sit in flops and update
// at acceptance, so back-to-back items see each other's effect. The mode register
// (CSR_MODE) picks whether pushes (0) or pops (1) are tied to the side register
// (CSR_SIDE). csr writes are always taken (csr_ready is high).
// Depends on rcd_pkg.
module restricted_circular_deque #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   // item channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic signed [31:0]  req_push_value,
   input  logic                req_free_side,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_popped_value,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic                csr_wdata
);

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

   function automatic logic [PtrW-1:0] wrap_up(input logic [PtrW-1:0] p);
      return (p == LastIdx) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PtrW-1:0] wrap_down(input logic [PtrW-1:0] p);
      return (p == '0) ? LastIdx : p - 1'b1;
   endfunction

   logic signed [31:0]  element_store_ff [DEPTH];
   logic signed [31:0]  rd_data_ff;

   logic [PtrW-1:0]     left_ff, left_in;
   logic [PtrW-1:0]     right_ff, right_in;
   logic                empty_ff, empty_in;
   logic                mode_ff, side_ff;

   logic                pend_valid_ff;
   rcd_pkg::status_type pend_status_ff, pend_status_in;
   logic                pend_ok_ff, pend_ok_in;

   logic                rsp_valid_ff;
   rcd_pkg::status_type rsp_status_ff;
   logic signed [31:0]  rsp_data_ff, rsp_data_in;

   logic                accept, out_free, full;
   logic                push_side, pop_side;
   logic                wr_en, rd_en;
   logic [PtrW-1:0]     wr_addr, rd_addr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign push_side = (mode_ff == rcd_pkg::MODE_IN_RESTRICTED) ? side_ff : req_free_side;
   assign pop_side  = (mode_ff == rcd_pkg::MODE_IN_RESTRICTED) ? req_free_side : side_ff;
   assign full      = !empty_ff && (left_ff == wrap_up(right_ff));

   always_comb begin
      left_in        = left_ff;
      right_in       = right_ff;
      empty_in       = empty_ff;
      pend_status_in = rcd_pkg::ST_DONE;
      pend_ok_in     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      rd_en          = 1'b0;
      rd_addr        = left_ff;
      if (accept) begin
         if (req_op == rcd_pkg::OP_PUSH) begin
            priority if (full) begin
               pend_status_in = rcd_pkg::ST_OVERFLOW;
            end else if (empty_ff) begin
               // first element always lands at entry 0
               left_in  = '0;
               right_in = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
            end else if (push_side == rcd_pkg::SIDE_LEFT) begin
               left_in = wrap_down(left_ff);
               wr_en   = 1'b1;
               wr_addr = wrap_down(left_ff);
            end else begin
               right_in = wrap_up(right_ff);
               wr_en    = 1'b1;
               wr_addr  = wrap_up(right_ff);
            end
         end else begin
            if (empty_ff) begin
               pend_status_in = rcd_pkg::ST_UNDERFLOW;
            end else begin
               rd_en      = 1'b1;
               pend_ok_in = 1'b1;
               rd_addr    = (pop_side == rcd_pkg::SIDE_LEFT) ? left_ff : right_ff;
               priority if (left_ff == right_ff) begin
                  left_in  = '0;
                  right_in = '0;
                  empty_in = 1'b1;
               end else if (pop_side == rcd_pkg::SIDE_LEFT) begin
                  left_in = wrap_up(left_ff);
               end else begin
                  right_in = wrap_down(right_ff);
               end
            end
         end
      end
   end

   assign rsp_data_in = pend_ok_ff ? rd_data_ff : '0;

   // store: one write or one read per item, never both
   always_ff @(posedge clock) begin
      if (wr_en) begin
         element_store_ff[wr_addr] <= req_push_value;
      end
      if (rd_en) begin
         rd_data_ff <= element_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         right_ff      <= '0;
         empty_ff      <= 1'b1;
         mode_ff       <= rcd_pkg::MODE_IN_RESTRICTED;
         side_ff       <= rcd_pkg::SIDE_LEFT;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         empty_ff <= empty_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rcd_pkg::CSR_MODE: mode_ff <= csr_wdata;
               rcd_pkg::CSR_SIDE: side_ff <= csr_wdata;
               default:           mode_ff <= mode_ff;
            endcase
         end
         if (accept) begin
            pend_valid_ff <= 1'b1;
         end else if (out_free) begin
            pend_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= pend_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= pend_status_in;
         pend_ok_ff     <= pend_ok_in;
      end
      if (out_free && pend_valid_ff) begin
         rsp_status_ff <= pend_status_ff;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_data_ff;

endmodule

FILE: rtl/rcd_checker.sv
// Port-level checker for the restricted circular deque, bound to the top level.
// Depends on rcd_pkg and restricted_circular_deque_macros.svh.
`include "restricted_circular_deque_macros.svh"

module rcd_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic signed [31:0]  rsp_popped_value,
   input logic                csr_valid,
   input logic                csr_ready
);

   // a held result keeps its contents
   `RCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_popped_value))

   // only a successful pop carries a value
   `RCD_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && (rsp_status != rcd_pkg::ST_DONE), rsp_popped_value == '0)

   // nothing comes out straight after reset
   `RCD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // configuration writes are never refused
   `RCD_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind restricted_circular_deque rcd_checker u_rcd_checker (.*);

FILE: tb/restricted_circular_deque_tb.sv
// Self-checking testbench for restricted_circular_deque: directed and random push/pop items.
// It predicts each result internally and compares results in order.
// Depends on rcd_pkg and the restricted_circular_deque RTL.
`timescale 1ns / 1ps

module restricted_circular_deque_tb;

   localparam int Depth       = 16;
   localparam int DrainCycles = 4;
   localparam int CycleLimit  = 200000;

   typedef logic [$clog2(Depth)-1:0] ptr_type;

   typedef struct packed {
      rcd_pkg::status_type status;
      logic signed [31:0]  value;
   } deque_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_op;
   logic signed [31:0] req_push_value;
   logic               req_free_side;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_popped_value;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic               csr_wdata;

   // shadow copy of the deque and its registers
   logic [31:0]       shadow_store [Depth];
   ptr_type           left_ptr;
   ptr_type           right_ptr;
   logic              shadow_empty;
   rcd_pkg::mode_type mode_cfg;
   rcd_pkg::side_type side_cfg;

   deque_result_type expected_results [$];
   int               error_count;
   int               cycle_count;
   bit               idle_on;

   restricted_circular_deque dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_push_value   (req_push_value),
      .req_free_side    (req_free_side),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // applies one item to the shadow deque and returns the result it should give
   function automatic deque_result_type deque_apply(input rcd_pkg::op_type op,
                                                    input logic [31:0] value,
                                                    input rcd_pkg::side_type free_side);
      deque_result_type  res;
      rcd_pkg::side_type side;
      logic              full;
      res.status = rcd_pkg::ST_DONE;
      res.value  = '0;
      full = !shadow_empty && (left_ptr == ptr_type'(right_ptr + 1'b1));
      if (op == rcd_pkg::OP_PUSH) begin
         side = (mode_cfg == rcd_pkg::MODE_IN_RESTRICTED) ? side_cfg : free_side;
         if (full) begin
            res.status = rcd_pkg::ST_OVERFLOW;
         end else if (shadow_empty) begin
            // first element always lands in entry 0
            left_ptr        = '0;
            right_ptr       = '0;
            shadow_empty    = 1'b0;
            shadow_store[0] = value;
         end else if (side == rcd_pkg::SIDE_LEFT) begin
            left_ptr               = ptr_type'(left_ptr - 1'b1);
            shadow_store[left_ptr] = value;
         end else begin
            right_ptr               = ptr_type'(right_ptr + 1'b1);
            shadow_store[right_ptr] = value;
         end
      end else begin
         side = (mode_cfg == rcd_pkg::MODE_IN_RESTRICTED) ? free_side : side_cfg;
         if (shadow_empty) begin
            res.status = rcd_pkg::ST_UNDERFLOW;
         end else begin
            res.value = (side == rcd_pkg::SIDE_LEFT) ? shadow_store[left_ptr]
                                                     : shadow_store[right_ptr];
            if (left_ptr == right_ptr) begin
               left_ptr     = '0;
               right_ptr    = '0;
               shadow_empty = 1'b1;
            end else if (side == rcd_pkg::SIDE_LEFT) begin
               left_ptr = ptr_type'(left_ptr + 1'b1);
            end else begin
               right_ptr = ptr_type'(right_ptr - 1'b1);
            end
         end
      end
      return res;
   endfunction

   // register writes, item predictions and result checks, all at the clock edge
   always @(posedge clock) begin : monitor
      deque_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == rcd_pkg::CSR_MODE) begin
               mode_cfg = rcd_pkg::mode_type'(csr_wdata);
            end else begin
               side_cfg = rcd_pkg::side_type'(csr_wdata);
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(deque_apply(rcd_pkg::op_type'(req_op),
                                                   req_push_value,
                                                   rcd_pkg::side_type'(req_free_side)));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected: status %0d value %0d",
                        $time, rsp_status, rsp_popped_value);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
               if (rsp_popped_value !== want.value) begin
                  $display("%0t: popped_value expected %0d actual %0d",
                           $time, want.value, rsp_popped_value);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
         $display("restricted_circular_deque_tb: errors");
         $finish;
      end
   end

   // result-side back-pressure in random bursts
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a clock edge; returns at the edge where the item is taken, valid left high
   task automatic send_item(input rcd_pkg::op_type op, input logic [31:0] value,
                            input rcd_pkg::side_type side);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_push_value <= value;
      req_free_side  <= side;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_config(input rcd_pkg::mode_type mode, input rcd_pkg::side_type side);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_index <= rcd_pkg::CSR_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= rcd_pkg::CSR_SIDE;
      csr_wdata <= side;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random_items(input int count, input int push_pct);
      rcd_pkg::op_type op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(1, 100) <= push_pct) ? rcd_pkg::OP_PUSH : rcd_pkg::OP_POP;
         send_item(op, pick_value(), rcd_pkg::side_type'($urandom_range(0, 1)));
      end
   endtask

   // pops on an empty deque from both sides, in the reset mode
   task automatic test_underflow();
      send_item(rcd_pkg::OP_POP, 32'h0000_0000, rcd_pkg::SIDE_LEFT);
      send_item(rcd_pkg::OP_POP, 32'hffff_ffff, rcd_pkg::SIDE_RIGHT);
   endtask

   // push then pop of a lone element, which empties the deque again
   task automatic test_single_element();
      send_item(rcd_pkg::OP_PUSH, 32'h7fff_ffff, rcd_pkg::SIDE_RIGHT);
      send_item(rcd_pkg::OP_POP, 32'h1234_5678, rcd_pkg::SIDE_RIGHT);
      send_item(rcd_pkg::OP_PUSH, 32'h8000_0000, rcd_pkg::SIDE_LEFT);
      send_item(rcd_pkg::OP_POP, 32'h0000_0000, rcd_pkg::SIDE_LEFT);
   endtask

   // fill from both ends so the left pointer wraps, then push once more
   task automatic test_overflow_wrap();
      logic [31:0] fill;
      write_config(rcd_pkg::MODE_OUT_RESTRICTED, rcd_pkg::SIDE_RIGHT);
      for (int i = 0; i < Depth; i++) begin
         case (i)
            0:       fill = 32'h7fff_ffff;
            1:       fill = 32'h8000_0000;
            2:       fill = 32'hffff_ffff;
            3:       fill = 32'h0000_0000;
            default: fill = 32'ha5a5_0000 ^ i;
         endcase
         send_item(rcd_pkg::OP_PUSH, fill, rcd_pkg::side_type'(i[0]));
      end
      send_item(rcd_pkg::OP_PUSH, 32'h5555_aaaa, rcd_pkg::SIDE_LEFT);
      send_item(rcd_pkg::OP_POP, $urandom, rcd_pkg::SIDE_LEFT);
      send_item(rcd_pkg::OP_POP, $urandom, rcd_pkg::SIDE_RIGHT);
   endtask

   // phases over all four settings, leaning towards full, empty or balanced
   task automatic test_random_phases();
      int push_pct;
      for (int p = 0; p < 7; p++) begin
         write_config(rcd_pkg::mode_type'(p[1]), rcd_pkg::side_type'(p[0]));
         case (p % 3)
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         run_random_items(200, push_pct);
      end
   endtask

   // full-rate traffic, no gaps or stalls
   task automatic test_back_to_back();
      write_config(rcd_pkg::MODE_IN_RESTRICTED, rcd_pkg::SIDE_RIGHT);
      idle_on = 1'b0;
      run_random_items(125, 55);
   endtask

   initial begin
      clock          = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= rcd_pkg::OP_PUSH;
      req_push_value <= '0;
      req_free_side  <= rcd_pkg::SIDE_LEFT;
      csr_valid      <= 1'b0;
      csr_index      <= rcd_pkg::CSR_MODE;
      csr_wdata      <= 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      idle_on        = 1'b1;
      left_ptr       = '0;
      right_ptr      = '0;
      shadow_empty   = 1'b1;
      mode_cfg       = rcd_pkg::MODE_IN_RESTRICTED;
      side_cfg       = rcd_pkg::SIDE_LEFT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_underflow();
      test_single_element();
      test_overflow_wrap();
      test_random_phases();
      test_back_to_back();

      wait_until_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("restricted_circular_deque_tb: clean");
      end else begin
         $display("restricted_circular_deque_tb: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/rcd_pkg.sv
rtl/restricted_circular_deque.sv
rtl/rcd_checker.sv
tb/restricted_circular_deque_tb.sv
